FILE: hw/rtl/cmfs_pkg.sv
// Shared face codes and sizing helpers for the cube map face select block.
`timescale 1ns / 1ps

package cmfs_pkg;

    // Width of the face code on the result beat.
    localparam int FACE_W = 3;

    // Cube faces, numbered as the texture unit expects them.
    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Face reported when no axis is strictly largest.
    localparam face_t FACE_DEFAULT = FACE_POS_Z;

endpackage

FILE: hw/rtl/cmfs_front.sv
// Front end: magnitudes, major axis selection and divider setup in three stages.
`timescale 1ns / 1ps

module cmfs_front #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Upstream side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COMP_WIDTH-1:0]  dir_x,
    input  logic signed [COMP_WIDTH-1:0]  dir_y,
    input  logic signed [COMP_WIDTH-1:0]  dir_z,
    // Downstream side
    output logic                          out_valid,
    input  logic                          out_ready,
    output cmfs_pkg::face_t               out_face,
    output logic [COMP_WIDTH:0]           out_rem_u,
    output logic [COMP_WIDTH:0]           out_rem_v,
    output logic [COMP_WIDTH:0]           out_div
);

    localparam int SW = COMP_WIDTH + 1;

    // Stage 1: sign-extended components and their magnitudes.
    logic                   s1_valid_reg;
    logic signed [SW-1:0]   s1_x_reg, s1_y_reg, s1_z_reg;
    logic [COMP_WIDTH-1:0]  s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic signed [SW-1:0]   s1_x_next, s1_y_next, s1_z_next;
    logic signed [SW-1:0]   s1_nx, s1_ny, s1_nz;
    logic [COMP_WIDTH-1:0]  s1_ax_next, s1_ay_next, s1_az_next;

    // Stage 2: selected face, major magnitude and signed minor components.
    logic                   s2_valid_reg;
    cmfs_pkg::face_t        s2_face_reg, s2_face_next;
    logic [COMP_WIDTH-1:0]  s2_m_reg, s2_m_next;
    logic signed [SW-1:0]   s2_nu_reg, s2_nv_reg, s2_nu_next, s2_nv_next;

    // Stage 3: starting remainders and divisor for the long division.
    logic                   s3_valid_reg;
    cmfs_pkg::face_t        s3_face_reg;
    logic [SW-1:0]          s3_rem_u_reg, s3_rem_v_reg, s3_div_reg;
    logic [SW-1:0]          s3_rem_u_next, s3_rem_v_next, s3_div_next;

    logic s1_ready, s2_ready, s3_ready;
    logic x_major, y_major, z_major;

    // A stage takes a beat when it is empty or its contents move on.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1 datapath.
    always_comb
    begin
        s1_x_next  = SW'(dir_x);
        s1_y_next  = SW'(dir_y);
        s1_z_next  = SW'(dir_z);
        s1_nx      = -s1_x_next;
        s1_ny      = -s1_y_next;
        s1_nz      = -s1_z_next;
        s1_ax_next = s1_x_next[SW-1] ? s1_nx[COMP_WIDTH-1:0] : s1_x_next[COMP_WIDTH-1:0];
        s1_ay_next = s1_y_next[SW-1] ? s1_ny[COMP_WIDTH-1:0] : s1_y_next[COMP_WIDTH-1:0];
        s1_az_next = s1_z_next[SW-1] ? s1_nz[COMP_WIDTH-1:0] : s1_z_next[COMP_WIDTH-1:0];
    end

    // Stage 2 datapath. With no strict maximum, m = 1 and zero minors give one half.
    always_comb
    begin
        x_major = (s1_ax_reg > s1_ay_reg) && (s1_ax_reg > s1_az_reg);
        y_major = (s1_ay_reg > s1_ax_reg) && (s1_ay_reg > s1_az_reg);
        z_major = (s1_az_reg > s1_ax_reg) && (s1_az_reg > s1_ay_reg);
        s2_face_next = cmfs_pkg::FACE_DEFAULT;
        s2_m_next    = COMP_WIDTH'(1);
        s2_nu_next   = '0;
        s2_nv_next   = '0;
        if (x_major)
        begin
            s2_m_next  = s1_ax_reg;
            s2_nv_next = s1_y_reg;
            if (!s1_x_reg[SW-1])
            begin
                s2_face_next = cmfs_pkg::FACE_POS_X;
                s2_nu_next   = -s1_z_reg;
            end
            else
            begin
                s2_face_next = cmfs_pkg::FACE_NEG_X;
                s2_nu_next   = s1_z_reg;
            end
        end
        else if (y_major)
        begin
            s2_m_next  = s1_ay_reg;
            s2_nu_next = s1_x_reg;
            if (!s1_y_reg[SW-1])
            begin
                s2_face_next = cmfs_pkg::FACE_POS_Y;
                s2_nv_next   = -s1_z_reg;
            end
            else
            begin
                s2_face_next = cmfs_pkg::FACE_NEG_Y;
                s2_nv_next   = s1_z_reg;
            end
        end
        else if (z_major)
        begin
            s2_m_next  = s1_az_reg;
            s2_nv_next = s1_y_reg;
            if (!s1_z_reg[SW-1])
            begin
                s2_face_next = cmfs_pkg::FACE_POS_Z;
                s2_nu_next   = s1_x_reg;
            end
            else
            begin
                s2_face_next = cmfs_pkg::FACE_NEG_Z;
                s2_nu_next   = -s1_x_reg;
            end
        end
    end

    // Stage 3 datapath. n + m lies in (0, 2m), so it is already below the divisor.
    always_comb
    begin
        s3_rem_u_next = SW'(s2_nu_reg + $signed({1'b0, s2_m_reg}));
        s3_rem_v_next = SW'(s2_nv_reg + $signed({1'b0, s2_m_reg}));
        s3_div_next   = {s2_m_reg, 1'b0};
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_x_reg  <= s1_x_next;
            s1_y_reg  <= s1_y_next;
            s1_z_reg  <= s1_z_next;
            s1_ax_reg <= s1_ax_next;
            s1_ay_reg <= s1_ay_next;
            s1_az_reg <= s1_az_next;
        end
        if (s2_ready)
        begin
            s2_face_reg <= s2_face_next;
            s2_m_reg    <= s2_m_next;
            s2_nu_reg   <= s2_nu_next;
            s2_nv_reg   <= s2_nv_next;
        end
        if (s3_ready)
        begin
            s3_face_reg  <= s2_face_reg;
            s3_rem_u_reg <= s3_rem_u_next;
            s3_rem_v_reg <= s3_rem_v_next;
            s3_div_reg   <= s3_div_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_face  = s3_face_reg;
    assign out_rem_u = s3_rem_u_reg;
    assign out_rem_v = s3_rem_v_reg;
    assign out_div   = s3_div_reg;

endmodule

FILE: hw/rtl/cmfs_div_stage.sv
// One restoring division step for both coordinates, with its pipeline register.
`timescale 1ns / 1ps

module cmfs_div_stage #(
    parameter int COMP_WIDTH   = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Upstream side
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cmfs_pkg::face_t          in_face,
    input  logic [COMP_WIDTH:0]      in_rem_u,
    input  logic [COMP_WIDTH:0]      in_rem_v,
    input  logic [COMP_WIDTH:0]      in_div,
    input  logic [UV_FRAC_BITS-1:0]  in_quo_u,
    input  logic [UV_FRAC_BITS-1:0]  in_quo_v,
    // Downstream side
    output logic                     out_valid,
    input  logic                     out_ready,
    output cmfs_pkg::face_t          out_face,
    output logic [COMP_WIDTH:0]      out_rem_u,
    output logic [COMP_WIDTH:0]      out_rem_v,
    output logic [COMP_WIDTH:0]      out_div,
    output logic [UV_FRAC_BITS-1:0]  out_quo_u,
    output logic [UV_FRAC_BITS-1:0]  out_quo_v
);

    localparam int RW = COMP_WIDTH + 1;

    logic                     valid_reg;
    cmfs_pkg::face_t          face_reg;
    logic [RW-1:0]            rem_u_reg, rem_v_reg, div_reg;
    logic [RW-1:0]            rem_u_next, rem_v_next;
    logic [UV_FRAC_BITS-1:0]  quo_u_reg, quo_v_reg, quo_u_next, quo_v_next;
    logic [RW:0]              shift_u, shift_v, diff_u, diff_v;
    logic                     bit_u, bit_v;

    assign in_ready = !valid_reg || out_ready;

    // Double the remainder and subtract the divisor where it fits.
    always_comb
    begin
        shift_u    = {in_rem_u, 1'b0};
        shift_v    = {in_rem_v, 1'b0};
        diff_u     = shift_u - {1'b0, in_div};
        diff_v     = shift_v - {1'b0, in_div};
        bit_u      = !diff_u[RW];
        bit_v      = !diff_v[RW];
        rem_u_next = bit_u ? diff_u[RW-1:0] : shift_u[RW-1:0];
        rem_v_next = bit_v ? diff_v[RW-1:0] : shift_v[RW-1:0];
        quo_u_next = {in_quo_u[UV_FRAC_BITS-2:0], bit_u};
        quo_v_next = {in_quo_v[UV_FRAC_BITS-2:0], bit_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            face_reg  <= in_face;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            div_reg   <= in_div;
            quo_u_reg <= quo_u_next;
            quo_v_reg <= quo_v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_face  = face_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_div   = div_reg;
    assign out_quo_u = quo_u_reg;
    assign out_quo_v = quo_v_reg;

endmodule

FILE: hw/rtl/cube_map_face_select_core.sv
// Path: a beat passes the front-end stages, then the divider stages, to the output.
// Throughput: one beat per cycle unless stalled; each divider stage makes a u and v bit.
// Every stage holds its own valid bit and fills bubbles, so a stalled output still
// lets earlier stages accept beats until the pipeline is full.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module cube_map_face_select_core #(
    parameter int COMP_WIDTH   = 16,
    parameter int UV_FRAC_BITS = 16,
    localparam int IN_W  = ((3 * COMP_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((cmfs_pkg::FACE_W + 2 * UV_FRAC_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // dir_x, dir_y, dir_z, zero pad
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata    // face, u_coord, v_coord, zero pad
);

    localparam int NS = UV_FRAC_BITS;
    localparam int RW = COMP_WIDTH + 1;
    localparam int FW = cmfs_pkg::FACE_W;

    // Hand-off signals between the front end and the divider chain.
    logic                     pv    [NS+1];
    logic                     pr    [NS+1];
    cmfs_pkg::face_t          pface [NS+1];
    logic [RW-1:0]            prem_u[NS+1];
    logic [RW-1:0]            prem_v[NS+1];
    logic [RW-1:0]            pdiv  [NS+1];
    logic [UV_FRAC_BITS-1:0]  pquo_u[NS+1];
    logic [UV_FRAC_BITS-1:0]  pquo_v[NS+1];

    // Unpack the input beat and run the front end.
    cmfs_front #(
        .COMP_WIDTH(COMP_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .dir_x    (s_axis_tdata[COMP_WIDTH-1:0]),
        .dir_y    (s_axis_tdata[2*COMP_WIDTH-1:COMP_WIDTH]),
        .dir_z    (s_axis_tdata[3*COMP_WIDTH-1:2*COMP_WIDTH]),
        .out_valid(pv[0]),
        .out_ready(pr[0]),
        .out_face (pface[0]),
        .out_rem_u(prem_u[0]),
        .out_rem_v(prem_v[0]),
        .out_div  (pdiv[0])
    );

    assign pquo_u[0] = '0;
    assign pquo_v[0] = '0;

    // Long division, one quotient bit per stage; the last stage is the output register.
    for (genvar i = 0; i < NS; i++)
    begin : g_div
        cmfs_div_stage #(
            .COMP_WIDTH  (COMP_WIDTH),
            .UV_FRAC_BITS(UV_FRAC_BITS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (pv[i]),
            .in_ready (pr[i]),
            .in_face  (pface[i]),
            .in_rem_u (prem_u[i]),
            .in_rem_v (prem_v[i]),
            .in_div   (pdiv[i]),
            .in_quo_u (pquo_u[i]),
            .in_quo_v (pquo_v[i]),
            .out_valid(pv[i+1]),
            .out_ready(pr[i+1]),
            .out_face (pface[i+1]),
            .out_rem_u(prem_u[i+1]),
            .out_rem_v(prem_v[i+1]),
            .out_div  (pdiv[i+1]),
            .out_quo_u(pquo_u[i+1]),
            .out_quo_v(pquo_v[i+1])
        );
    end

    assign m_axis_tvalid = pv[NS];
    assign pr[NS]        = m_axis_tready;

    // Pack the result beat.
    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[FW-1:0] = pface[NS];
        m_axis_tdata[FW+UV_FRAC_BITS-1:FW] = pquo_u[NS];
        m_axis_tdata[FW+2*UV_FRAC_BITS-1:FW+UV_FRAC_BITS] = pquo_v[NS];
    end

endmodule

FILE: hw/rtl/cmfs_checker.sv
// Port-level checks for the cube map face select core, bound to the top level.
`timescale 1ns / 1ps

module cmfs_checker #(
    parameter int IN_W  = 48,
    parameter int OUT_W = 40
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [IN_W-1:0]   s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata
);

    localparam int FW = cmfs_pkg::FACE_W;

    // No result beat is offered on the edge after reset has been seen.
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result beat offered during reset");

    // A face code on a result beat is always one of the six faces.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[FW-1:0] <= FW'(cmfs_pkg::FACE_NEG_Z)))
        else $error("face code out of range");

    // When the sink takes beats, the whole pipeline advances and input is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // A direction beat that waits for the core is held by the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting direction beat changed");

endmodule

bind cube_map_face_select_core cmfs_checker #(
    .IN_W (IN_W),
    .OUT_W(OUT_W)
) u_cmfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
